// ----- rtl/bit_array_shifter_top_defines.svh -----
// Assertion macros shared by the checker of the bit array shifter.
// Depends on nothing; included by the files that hold assertions.
`ifndef BIT_ARRAY_SHIFTER_TOP_DEFINES_SVH
`define BIT_ARRAY_SHIFTER_TOP_DEFINES_SVH

// Checked only while reset is released.
`define BAS_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define BAS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/bas_pkg.sv -----
// Shared constants and types of the bit array shifter.
// Depends on nothing; used by the cell, the chain and the top level.
package bas_pkg;

    localparam int MAX_BYTES = 64;
    localparam int IDX_W     = $clog2(MAX_BYTES);
    localparam int CNT_W     = $clog2(MAX_BYTES + 1);
    localparam int BYTE_W    = 8;
    localparam int SHIFT_W   = 11;
    localparam int ALIGN_W   = SHIFT_W - 3;

    typedef struct packed {
        logic              load;
        logic              shift;
        logic [IDX_W-1:0]  wr_idx;
        logic [BYTE_W-1:0] wdata;
    } cell_ctl_t;

endpackage

// ----- rtl/bas_cell.sv -----
// One byte cell of the storage chain.
// Depends on bas_pkg; instantiated by bas_chain.
module bas_cell (
    input  logic                      aclk,
    input  bas_pkg::cell_ctl_t        ctl,
    input  logic                      sel,
    input  logic [bas_pkg::BYTE_W-1:0] nbr_in,
    output logic [bas_pkg::BYTE_W-1:0] byte_out
);

    logic [bas_pkg::BYTE_W-1:0] byte_reg;
    logic [bas_pkg::BYTE_W-1:0] byte_next;

    always_comb begin
        byte_next = byte_reg;
        if (ctl.shift) begin
            byte_next = nbr_in;
        end else if (ctl.load && sel) begin
            byte_next = ctl.wdata;
        end
    end

    always_ff @(posedge aclk) begin
        byte_reg <= byte_next;
    end

    assign byte_out = byte_reg;

endmodule

// ----- rtl/bas_chain.sv -----
// Row of byte cells that shifts toward cell zero and shows the two head cells.
// Depends on bas_pkg and bas_cell; instantiated by the top level.
module bas_chain (
    input  logic                       aclk,
    input  bas_pkg::cell_ctl_t         ctl,
    output logic [bas_pkg::BYTE_W-1:0] head0,
    output logic [bas_pkg::BYTE_W-1:0] head1
);

    logic [bas_pkg::BYTE_W-1:0] cell_q [bas_pkg::MAX_BYTES];

    for (genvar i = 0; i < bas_pkg::MAX_BYTES; i++) begin : g_cell
        logic                       sel;
        logic [bas_pkg::BYTE_W-1:0] nbr;

        assign sel = (ctl.wr_idx == bas_pkg::IDX_W'(i));

        if (i == bas_pkg::MAX_BYTES - 1) begin : g_tail
            assign nbr = '0;
        end else begin : g_mid
            assign nbr = cell_q[i+1];
        end

        bas_cell u_cell (
            .aclk     (aclk),
            .ctl      (ctl),
            .sel      (sel),
            .nbr_in   (nbr),
            .byte_out (cell_q[i])
        );
    end

    assign head0 = cell_q[0];
    assign head1 = cell_q[1];

endmodule

// ----- rtl/bit_array_shifter_top.sv -----
// Top level of the bit array shifter: handshakes, sequencer and output register.
// Depends on bas_pkg and bas_chain.
//
// Channel | Ports                          | Contents
// s_      | s_tvalid s_tready s_tdata s_tlast | source byte, last mark
// m_      | m_tvalid m_tready m_tdata m_tlast | shifted byte, last mark
// cfg_    | cfg_valid cfg_ready cfg_data   | signed bit shift amount
//
// An array of n bytes is loaded at one byte per cycle.
// The last byte starts an alignment pass that drops min(q, n) head bytes
// for a byte shift q > 0 and none otherwise. Then one shifted byte per cycle leaves
// through the output register while m_tready does not stall it, n bytes in all.
// The next array is accepted as soon as the last shifted byte sits in the output register.
// Reset is synchronous and active low; the stored bytes are not cleared.
module bit_array_shifter_top (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [7:0]                        s_tdata,   // [7:0] data_byte
    input  logic                              s_tlast,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [7:0]                        m_tdata,   // [7:0] shifted_byte
    output logic                              m_tlast,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic signed [bas_pkg::SHIFT_W-1:0] cfg_data
);

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_SKIP,
        ST_EMIT
    } state_t;

    state_t                              state_reg;
    logic signed [bas_pkg::SHIFT_W-1:0]  shift_amount_reg;
    logic [bas_pkg::CNT_W-1:0]           count_reg;
    logic [bas_pkg::CNT_W-1:0]           avail_reg;
    logic [bas_pkg::CNT_W-1:0]           left_reg;
    logic [bas_pkg::ALIGN_W-1:0]         skip_reg;
    logic [bas_pkg::ALIGN_W-1:0]         lead_reg;
    logic [2:0]                          frac_reg;
    logic                                m_tvalid_reg;
    logic [bas_pkg::BYTE_W-1:0]          m_tdata_reg;
    logic                                m_tlast_reg;

    logic                                in_fire;
    logic                                has_room;
    logic                                emit_fire;
    logic                                skip_step;
    logic [bas_pkg::CNT_W-1:0]           n_bytes;
    logic [bas_pkg::ALIGN_W-1:0]         q_bytes;
    logic [bas_pkg::BYTE_W-1:0]          head0;
    logic [bas_pkg::BYTE_W-1:0]          head1;
    logic [bas_pkg::BYTE_W-1:0]          hi_byte;
    logic [bas_pkg::BYTE_W-1:0]          lo_byte;
    logic [2*bas_pkg::BYTE_W-1:0]        wide;
    bas_pkg::cell_ctl_t                  ctl;

    assign s_tready  = (state_reg == ST_LOAD);
    assign cfg_ready = 1'b1;
    assign in_fire   = s_tvalid && s_tready;
    assign has_room  = (count_reg < bas_pkg::CNT_W'(bas_pkg::MAX_BYTES));
    assign n_bytes   = has_room ? count_reg + 1'b1 : count_reg;
    assign q_bytes   = shift_amount_reg[bas_pkg::SHIFT_W-1:3];
    assign emit_fire = (state_reg == ST_EMIT) && (!m_tvalid_reg || m_tready);
    assign skip_step = (state_reg == ST_SKIP) && (skip_reg != '0) && (avail_reg != '0);

    always_comb begin
        ctl.load   = in_fire && has_room;
        ctl.shift  = skip_step || (emit_fire && (lead_reg == '0));
        ctl.wr_idx = count_reg[bas_pkg::IDX_W-1:0];
        ctl.wdata  = s_tdata;
    end

    bas_chain u_chain (
        .aclk  (aclk),
        .ctl   (ctl),
        .head0 (head0),
        .head1 (head1)
    );

    always_comb begin
        hi_byte = '0;
        lo_byte = '0;
        if (lead_reg == '0) begin
            hi_byte = (avail_reg > bas_pkg::CNT_W'(0)) ? head0 : '0;
            lo_byte = (avail_reg > bas_pkg::CNT_W'(1)) ? head1 : '0;
        end else if (lead_reg == bas_pkg::ALIGN_W'(1)) begin
            lo_byte = (avail_reg > bas_pkg::CNT_W'(0)) ? head0 : '0;
        end
        wide = {hi_byte, lo_byte} << frac_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_LOAD;
            shift_amount_reg <= '0;
            count_reg        <= '0;
            m_tvalid_reg     <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                shift_amount_reg <= cfg_data;
            end
            if (m_tready && !emit_fire) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_LOAD: begin
                    if (in_fire) begin
                        if (s_tlast) begin
                            count_reg <= '0;
                            avail_reg <= n_bytes;
                            left_reg  <= n_bytes;
                            frac_reg  <= shift_amount_reg[2:0];
                            if (q_bytes[bas_pkg::ALIGN_W-1]) begin
                                lead_reg <= ~q_bytes + 1'b1;
                                skip_reg <= '0;
                            end else begin
                                lead_reg <= '0;
                                skip_reg <= q_bytes;
                            end
                            state_reg <= ST_SKIP;
                        end else if (has_room) begin
                            count_reg <= count_reg + 1'b1;
                        end
                    end
                end
                ST_SKIP: begin
                    if (skip_step) begin
                        skip_reg  <= skip_reg - 1'b1;
                        avail_reg <= avail_reg - 1'b1;
                    end else begin
                        state_reg <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (emit_fire) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= wide[2*bas_pkg::BYTE_W-1:bas_pkg::BYTE_W];
                        m_tlast_reg  <= (left_reg == bas_pkg::CNT_W'(1));
                        left_reg     <= left_reg - 1'b1;
                        if (lead_reg != '0) begin
                            lead_reg <= lead_reg - 1'b1;
                        end else if (avail_reg != '0) begin
                            avail_reg <= avail_reg - 1'b1;
                        end
                        if (left_reg == bas_pkg::CNT_W'(1)) begin
                            state_reg <= ST_LOAD;
                        end
                    end
                end
                default: begin
                    state_reg <= ST_LOAD;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

// ----- rtl/bas_checker.sv -----
// Port-level checks of the bit array shifter, bound to the top level.
// Depends on bit_array_shifter_top_defines.svh and bit_array_shifter_top.
`include "bit_array_shifter_top_defines.svh"

module bas_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic       s_tlast,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast
);

    `BAS_ASSERT_ALWAYS(a_reset_clears_out, aclk, !aresetn |=> !m_tvalid, "output valid after reset")
    `BAS_ASSERT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast), "stalled item changed")
    `BAS_ASSERT(a_no_load_mid_out, aclk, aresetn, m_tvalid && !m_tlast |-> !s_tready, "input taken while results remain")
    `BAS_ASSERT(a_last_blocks_in, aclk, aresetn, s_tvalid && s_tready && s_tlast |=> !s_tready, "input taken right after last item")

endmodule

bind bit_array_shifter_top bas_checker u_bas_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

// ----- tb/tb_top.sv -----
// Self-checking testbench for bit_array_shifter_top: directed byte arrays, then random arrays.
// Each array is checked against a bit-level shift predictor; random arrays use random shift settings.
// Depends on bas_pkg and the RTL of bit_array_shifter_top.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 320;
    localparam int STALL_LIMIT  = 3000;
    localparam int DRAIN_PAUSE  = 8;

    typedef struct {
        logic [7:0] value;
        logic       last;
    } shifted_byte_t;

    typedef struct {
        bit         set_shift;
        int         shift;
        logic [7:0] data;
        bit         last;
        bit         known;
        logic [7:0] known_byte;
    } plan_row_t;

    logic                               aclk = 1'b0;
    logic                               aresetn = 1'b0;
    logic                               s_tvalid = 1'b0;
    logic                               s_tready;
    logic [7:0]                         s_tdata = '0;
    logic                               s_tlast = 1'b0;
    logic                               m_tvalid;
    logic                               m_tready = 1'b0;
    logic [7:0]                         m_tdata;
    logic                               m_tlast;
    logic                               cfg_valid = 1'b0;
    logic                               cfg_ready;
    logic signed [bas_pkg::SHIFT_W-1:0] cfg_data = '0;

    logic [7:0]                         held_bytes [bas_pkg::MAX_BYTES];
    int                                 held_count = 0;
    logic signed [bas_pkg::SHIFT_W-1:0] bit_shift = '0;
    shifted_byte_t                      shifted_q [$];

    int  mismatches = 0;
    int  bytes_checked = 0;
    int  bytes_sent = 0;
    int  arrays_sent = 0;
    int  long_arrays = 0;
    int  shift_writes = 0;
    int  quiet_cycles = 0;
    int  stall_left = 0;
    int  ready_roll;
    bit  calm = 1'b0;

    plan_row_t plan [24] = '{
        '{1, 0,     8'hA5, 1, 1, 8'hA5},
        '{1, 8,     8'hFF, 1, 1, 8'h00},
        '{1, -8,    8'h81, 1, 1, 8'h00},
        '{1, 1,     8'hFF, 1, 1, 8'hFE},
        '{1, -1,    8'hFF, 1, 1, 8'h7F},
        '{1, 1023,  8'h5A, 1, 1, 8'h00},
        '{1, -1024, 8'hC3, 1, 1, 8'h00},
        '{1, 3,     8'h12, 0, 0, 8'h00},
        '{0, 0,     8'h34, 0, 0, 8'h00},
        '{0, 0,     8'h56, 1, 0, 8'h00},
        '{1, -5,    8'h00, 0, 0, 8'h00},
        '{0, 0,     8'hFF, 0, 0, 8'h00},
        '{0, 0,     8'h80, 0, 0, 8'h00},
        '{0, 0,     8'h01, 1, 0, 8'h00},
        '{1, 512,   8'hDE, 0, 0, 8'h00},
        '{0, 0,     8'hAD, 1, 0, 8'h00},
        '{1, -512,  8'hBE, 0, 0, 8'h00},
        '{0, 0,     8'hEF, 1, 0, 8'h00},
        '{1, 15,    8'h01, 0, 0, 8'h00},
        '{0, 0,     8'h02, 0, 0, 8'h00},
        '{0, 0,     8'h03, 1, 0, 8'h00},
        '{1, -9,    8'hFF, 0, 0, 8'h00},
        '{0, 0,     8'h00, 0, 0, 8'h00},
        '{0, 0,     8'hAA, 1, 0, 8'h00}
    };

    bit_array_shifter_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #6 aclk = ~aclk;

    // Output bit i of the array is source bit i + shift, or zero outside the array.
    function automatic void absorb_byte(logic [7:0] data, logic last);
        int         pos;
        logic [7:0] acc;
        logic       bit_in;
        if (held_count < bas_pkg::MAX_BYTES) begin
            held_bytes[held_count] = data;
            held_count++;
        end
        if (last) begin
            for (int k = 0; k < held_count; k++) begin
                acc = '0;
                for (int b = 0; b < 8; b++) begin
                    pos = k * 8 + b + int'(bit_shift);
                    bit_in = 1'b0;
                    if (pos >= 0 && pos < held_count * 8) begin
                        bit_in = held_bytes[pos / 8][7 - pos % 8];
                    end
                    acc = {acc[6:0], bit_in};
                end
                shifted_q.push_back('{acc, (k == held_count - 1)});
            end
            held_count = 0;
            arrays_sent++;
        end
    endfunction

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (calm || roll < 60) begin
            return 0;
        end else if (roll < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 25);
    endfunction

    // Called at a falling edge; returns at the falling edge after the item is taken.
    task automatic push_byte(input logic [7:0] data, input logic last);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        absorb_byte(data, last);
        bytes_sent++;
        @(negedge aclk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (shifted_q.size() != 0) @(negedge aclk);
        repeat (DRAIN_PAUSE) @(negedge aclk);
    endtask

    task automatic write_shift(input int shift);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= bas_pkg::SHIFT_W'(shift);
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        bit_shift = bas_pkg::SHIFT_W'(shift);
        shift_writes++;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    function automatic int pick_shift(int len);
        int roll;
        int span;
        roll = $urandom_range(0, 99);
        span = 8 * len + 2;
        if (roll < 55) begin
            return $urandom_range(0, 2 * span) - span;
        end else if (roll < 70) begin
            return $urandom_range(0, 18) - 9;
        end else if (roll < 82) begin
            case ($urandom_range(0, 5))
                0: return -1024;
                1: return 1023;
                2: return -512;
                3: return 512;
                4: return 8 * len;
                default: return -8 * len;
            endcase
        end
        return $urandom_range(0, 2047) - 1024;
    endfunction

    function automatic int pick_length();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60) begin
            return $urandom_range(1, 6);
        end else if (roll < 85) begin
            return $urandom_range(7, 16);
        end else if (roll < 95) begin
            return $urandom_range(17, 40);
        end else if (roll < 98) begin
            return bas_pkg::MAX_BYTES;
        end
        return $urandom_range(bas_pkg::MAX_BYTES + 1, bas_pkg::MAX_BYTES + 8);
    endfunction

    always @(negedge aclk) begin
        if (stall_left > 0) begin
            m_tready <= 1'b0;
            stall_left--;
        end else if (calm) begin
            m_tready <= 1'b1;
        end else begin
            ready_roll = $urandom_range(0, 99);
            if (ready_roll < 70) begin
                m_tready <= 1'b1;
            end else if (ready_roll < 95) begin
                m_tready <= 1'b0;
                stall_left = $urandom_range(0, 2);
            end else begin
                m_tready <= 1'b0;
                stall_left = $urandom_range(8, 30);
            end
        end
    end

    always @(posedge aclk) begin
        shifted_byte_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (shifted_q.size() == 0) begin
                $error("unexpected output item: shifted_byte %h last_out %b", m_tdata, m_tlast);
                mismatches++;
            end else begin
                want = shifted_q.pop_front();
                bytes_checked++;
                if (m_tdata !== want.value) begin
                    $error("shifted_byte: expected %h, actual %h", want.value, m_tdata);
                    mismatches++;
                end
                if (m_tlast !== want.last) begin
                    $error("last_out: expected %b, actual %b", want.last, m_tlast);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
                $display("Timeout: no handshake for %0d cycles", STALL_LIMIT);
                $display("TEST FAILED");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    initial begin
        int len;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (plan[i]) begin
            if (plan[i].set_shift) begin
                write_shift(plan[i].shift);
            end
            push_byte(plan[i].data, plan[i].last);
            if (plan[i].last && plan[i].known) begin
                void'(shifted_q.pop_back());
                shifted_q.push_back('{plan[i].known_byte, 1'b1});
            end
        end

        while (bytes_sent < $size(plan) + RANDOM_ITEMS) begin
            len  = pick_length();
            calm = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 9) < 7) begin
                write_shift(pick_shift(len > bas_pkg::MAX_BYTES ? bas_pkg::MAX_BYTES : len));
            end
            if (len > bas_pkg::MAX_BYTES) begin
                long_arrays++;
            end
            for (int i = 0; i < len; i++) begin
                push_byte(8'($urandom_range(0, 255)), i == len - 1);
            end
        end

        calm = 1'b0;
        drain();
        repeat (20) @(negedge aclk);
        $display("Sent %0d arrays (%0d bytes, %0d over the store size) under %0d shift settings.",
                 arrays_sent, bytes_sent, long_arrays, shift_writes);
        $display("Checked %0d shifted bytes, %0d mismatches.", bytes_checked, mismatches);
        if (mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ----- bit_array_shifter_top.f -----
+incdir+rtl
rtl/bas_pkg.sv
rtl/bas_cell.sv
rtl/bas_chain.sv
rtl/bit_array_shifter_top.sv
rtl/bas_checker.sv
tb/tb_top.sv
